// ===== rtl/ducking_audio_mixer_defines.svh =====
// ----------------------------------------------------------------------------
// Ducking audio mixer assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef DUCKING_AUDIO_MIXER_DEFINES_SVH
`define DUCKING_AUDIO_MIXER_DEFINES_SVH

// same-cycle implication, quiet during reset
`define DAM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ducking_audio_mixer check failed");

// next-cycle implication, quiet during reset
`define DAM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ducking_audio_mixer check failed");

`endif

// ===== rtl/dam_pkg.sv =====
// ----------------------------------------------------------------------------
// Ducking audio mixer package
// Widths, reset values, register indexes and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dam_pkg;

	localparam int SAMPLE_W = 16;
	localparam int GAIN_W   = 25;
	localparam int FRAC_W   = 24;
	localparam int INDEX_W  = 8;

	localparam logic [GAIN_W-1:0] GAIN_ONE          = 25'd16777216;
	localparam logic [GAIN_W-1:0] DUCK_GAIN_RST     = 25'd8388608;
	localparam logic [GAIN_W-1:0] ATTACK_STEP_RST   = 25'd140;
	localparam logic [GAIN_W-1:0] RELEASE_STEP_RST  = 25'd14;

	typedef enum logic [INDEX_W-1:0] {
		REG_DUCK_GAIN    = 8'd0,
		REG_ATTACK_STEP  = 8'd1,
		REG_RELEASE_STEP = 8'd2,
		REG_FULL_DUPLEX  = 8'd3
	} reg_index_t;

	typedef struct packed {
		logic [GAIN_W-1:0] duck_gain;
		logic [GAIN_W-1:0] attack_step;
		logic [GAIN_W-1:0] release_step;
	} ramp_cfg_t;

endpackage

// ===== rtl/ducking_audio_mixer.sv =====
// ----------------------------------------------------------------------------
// Ducking audio mixer
// Mixes receive, link and ducked telemetry audio into one saturated sample.
// ----------------------------------------------------------------------------
// One sample per beat, one result per sample, one beat per clock sustained
// while m_tready is high. Registers in order: input with the ramped gain,
// 16 x 25 multiply, then round/add/saturate output. A stage stalls only
// when it and all later stages are full and m_tready is low; s_tready stays
// high while any stage has room. The tone gain ramps once per accepted beat,
// before use. Config writes are taken every cycle (cfg_ready is always high)
// and are meant for idle periods. No start-up delay after reset.
`timescale 1ns / 1ps

module ducking_audio_mixer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // rx_sample, link_sample, tone_sample
	input  logic [2:0]  s_tuser,   // receiving, link_busy, tone_valid
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // mixed_sample
	output logic [0:0]  m_tuser,   // clipped
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [24:0] cfg_data
);

	localparam int BASE_W = dam_pkg::SAMPLE_W + 1;
	localparam int PROD_W = dam_pkg::SAMPLE_W + dam_pkg::GAIN_W;
	localparam int TONE_W = PROD_W - dam_pkg::FRAC_W + 2;
	localparam int SUM_W  = TONE_W + 1;

	// config registers
	dam_pkg::ramp_cfg_t cfg_q;
	logic               full_duplex_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.duck_gain    <= dam_pkg::DUCK_GAIN_RST;
			cfg_q.attack_step  <= dam_pkg::ATTACK_STEP_RST;
			cfg_q.release_step <= dam_pkg::RELEASE_STEP_RST;
			full_duplex_q      <= 1'b0;
		end else if (cfg_valid) begin
			unique case (dam_pkg::reg_index_t'(cfg_index))
				dam_pkg::REG_DUCK_GAIN:    cfg_q.duck_gain    <= cfg_data;
				dam_pkg::REG_ATTACK_STEP:  cfg_q.attack_step  <= cfg_data;
				dam_pkg::REG_RELEASE_STEP: cfg_q.release_step <= cfg_data;
				dam_pkg::REG_FULL_DUPLEX:  full_duplex_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	// input fields
	logic signed [dam_pkg::SAMPLE_W-1:0] rx_sample;
	logic signed [dam_pkg::SAMPLE_W-1:0] link_sample;
	logic signed [dam_pkg::SAMPLE_W-1:0] tone_sample;
	logic                                receiving;
	logic                                link_busy;
	logic                                tone_valid;

	assign rx_sample   = s_tdata[15:0];
	assign link_sample = s_tdata[31:16];
	assign tone_sample = s_tdata[47:32];
	assign receiving   = s_tuser[0];
	assign link_busy   = s_tuser[1];
	assign tone_valid  = s_tuser[2];

	// pipeline control
	logic valid_s1, valid_s2, m_valid_q;
	logic ce_out, ce_s2, ce_s1, accept;

	assign ce_out   = !m_valid_q || m_tready;
	assign ce_s2    = !valid_s2 || ce_out;
	assign ce_s1    = !valid_s1 || ce_s2;
	assign s_tready = ce_s1;
	assign accept   = s_tvalid && ce_s1;

	// gain ramp
	logic [dam_pkg::GAIN_W-1:0] gain;

	dam_gain_ramp u_ramp (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (accept),
		.toward_duck (receiving || link_busy),
		.cfg         (cfg_q),
		.gain        (gain)
	);

	// stage 1 inputs
	logic                                rx_en, link_en;
	logic signed [BASE_W-1:0]            base_in;
	logic [dam_pkg::SAMPLE_W-1:0]        tone_mag_in;

	assign rx_en   = full_duplex_q && receiving;
	assign link_en = (full_duplex_q || !receiving) && link_busy;
	assign base_in = (rx_en ? BASE_W'(rx_sample) : '0)
		+ (link_en ? BASE_W'(link_sample) : '0);
	assign tone_mag_in = !tone_valid ? '0
		: tone_sample[dam_pkg::SAMPLE_W-1] ? dam_pkg::SAMPLE_W'(~tone_sample + 1'b1)
		: dam_pkg::SAMPLE_W'(tone_sample);

	logic signed [BASE_W-1:0]     base_s1, base_s2;
	logic [dam_pkg::SAMPLE_W-1:0] tmag_s1;
	logic                         tneg_s1, tneg_s2;
	logic [PROD_W-1:0]            prod_s2;
	logic [15:0]                  mixed_q;
	logic                         clip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (ce_s1) valid_s1 <= s_tvalid;
			if (ce_s2) valid_s2 <= valid_s1;
			if (ce_out) m_valid_q <= valid_s2;
		end
	end

	// rounding, sum and saturation
	logic [PROD_W:0]           rounded;
	logic [TONE_W-2:0]         tone_abs;
	logic signed [TONE_W-1:0]  tone_term;
	logic signed [SUM_W-1:0]   total;
	logic                      sat_hi, sat_lo;

	assign rounded   = {1'b0, prod_s2} + ((PROD_W+1)'(1) << (dam_pkg::FRAC_W - 1));
	assign tone_abs  = rounded[PROD_W:dam_pkg::FRAC_W];
	assign tone_term = tneg_s2 ? -$signed({1'b0, tone_abs}) : $signed({1'b0, tone_abs});
	assign total     = SUM_W'(base_s2) + SUM_W'(tone_term);
	assign sat_hi    = total > SUM_W'(32767);
	assign sat_lo    = total < -SUM_W'(32768);

	always_ff @(posedge clk) begin
		if (accept) begin
			base_s1 <= base_in;
			tmag_s1 <= tone_mag_in;
			tneg_s1 <= tone_sample[dam_pkg::SAMPLE_W-1];
		end
		if (ce_s2 && valid_s1) begin
			base_s2 <= base_s1;
			tneg_s2 <= tneg_s1;
			prod_s2 <= PROD_W'(tmag_s1) * PROD_W'(gain);
		end
		if (ce_out && valid_s2) begin
			mixed_q <= sat_hi ? 16'h7FFF : sat_lo ? 16'h8000 : total[15:0];
			clip_q  <= sat_hi || sat_lo;
		end
	end

	assign m_tvalid   = m_valid_q;
	assign m_tdata    = mixed_q;
	assign m_tuser[0] = clip_q;

endmodule

// ===== rtl/dam_gain_ramp.sv =====
// ----------------------------------------------------------------------------
// Ducking gain ramp
// Holds the tone gain and moves it one step toward its target per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dam_gain_ramp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  logic                        toward_duck,
	input  dam_pkg::ramp_cfg_t          cfg,
	output logic [dam_pkg::GAIN_W-1:0]  gain
);

	logic [dam_pkg::GAIN_W-1:0] ramp_gain_q;
	logic [dam_pkg::GAIN_W-1:0] target;
	logic [dam_pkg::GAIN_W-1:0] dist_down;
	logic [dam_pkg::GAIN_W-1:0] dist_up;
	logic [dam_pkg::GAIN_W-1:0] gain_next;

	assign target    = toward_duck ? cfg.duck_gain : dam_pkg::GAIN_ONE;
	assign dist_down = ramp_gain_q - target;
	assign dist_up   = target - ramp_gain_q;

	always_comb begin
		priority if (ramp_gain_q > target) begin
			gain_next = (dist_down <= cfg.attack_step) ? target
				: ramp_gain_q - cfg.attack_step;
		end else begin
			gain_next = (dist_up <= cfg.release_step) ? target
				: ramp_gain_q + cfg.release_step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_gain_q <= dam_pkg::GAIN_ONE;
		end else if (advance) begin
			ramp_gain_q <= gain_next;
		end
	end

	assign gain = ramp_gain_q;

endmodule

// ===== rtl/dam_port_checker.sv =====
// ----------------------------------------------------------------------------
// Ducking audio mixer port checker
// Watches the top-level ports for flow control and output value slips.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ducking_audio_mixer_defines.svh"

module dam_port_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [0:0]  m_tuser,
	input logic        cfg_ready
);

	`DAM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	`DAM_ASSERT_NOW(a_clip_rail, m_tvalid && m_tuser[0], m_tdata == 16'h7FFF || m_tdata == 16'h8000)
	`DAM_ASSERT_NOW(a_backpressure, !s_tready, m_tvalid && !m_tready)
	`DAM_ASSERT_NOW(a_cfg_open, s_tvalid || !s_tvalid, cfg_ready)

endmodule

bind ducking_audio_mixer dam_port_checker u_dam_port_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tuser   (m_tuser),
	.cfg_ready (cfg_ready)
);

// ===== dv/tb_ducking_audio_mixer.sv =====
// ----------------------------------------------------------------------------
// Ducking audio mixer testbench
// Drives sample beats with random idle and stall bursts and predicts every
// mixed sample, including the ducking gain ramp, rounding and saturation.
// Compares each output beat against the oldest prediction. The gain settings
// and the duplex mode change between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ducking_audio_mixer;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PRINT_CAP   = 40;

	typedef struct {
		logic signed [dam_pkg::SAMPLE_W-1:0] rx_sample;
		logic                                receiving;
		logic                                link_busy;
		logic signed [dam_pkg::SAMPLE_W-1:0] link_sample;
		logic                                tone_valid;
		logic signed [dam_pkg::SAMPLE_W-1:0] tone_sample;
	} mix_in_t;

	typedef struct {
		logic [dam_pkg::SAMPLE_W-1:0] mixed_sample;
		logic                         clipped;
	} mix_out_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata   = '0;   // rx_sample, link_sample, tone_sample
	logic [2:0]  s_tuser   = '0;   // receiving, link_busy, tone_valid
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [15:0] m_tdata;          // mixed_sample
	logic [0:0]  m_tuser;          // clipped
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index = '0;
	logic [24:0] cfg_data  = '0;

	// predictor copy of the registers and the ramp
	logic [dam_pkg::GAIN_W-1:0] cfg_duck    = dam_pkg::DUCK_GAIN_RST;
	logic [dam_pkg::GAIN_W-1:0] cfg_attack  = dam_pkg::ATTACK_STEP_RST;
	logic [dam_pkg::GAIN_W-1:0] cfg_release = dam_pkg::RELEASE_STEP_RST;
	logic                       cfg_duplex  = 1'b0;
	logic [dam_pkg::GAIN_W-1:0] tone_gain   = dam_pkg::GAIN_ONE;

	mix_in_t  sample_q[$];
	mix_out_t mix_due[$];
	mix_in_t  tx_beat;
	int       tx_gap     = 0;
	int       tx_calm    = 0;
	int       rx_stall   = 0;
	int       mismatches = 0;
	int       cycle_count = 0;
	logic     no_idle    = 1'b0;

	ducking_audio_mixer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// ramp first, then mix with the new gain
	function automatic mix_out_t mix_predict(input mix_in_t s);
		logic [dam_pkg::GAIN_W-1:0] target;
		longint acc;
		longint mag;
		longint scaled;
		mix_out_t r;
		target = (s.receiving || s.link_busy) ? cfg_duck : dam_pkg::GAIN_ONE;
		if (tone_gain > target) begin
			if (tone_gain - target <= cfg_attack) tone_gain = target;
			else tone_gain = tone_gain - cfg_attack;
		end else if (target - tone_gain <= cfg_release) begin
			tone_gain = target;
		end else begin
			tone_gain = tone_gain + cfg_release;
		end
		acc = 0;
		if (cfg_duplex && s.receiving) acc += s.rx_sample;
		if ((cfg_duplex || !s.receiving) && s.link_busy) acc += s.link_sample;
		if (s.tone_valid) begin
			mag = (s.tone_sample < 0) ? -longint'(s.tone_sample) : longint'(s.tone_sample);
			scaled = (mag * longint'(tone_gain) + (longint'(1) << (dam_pkg::FRAC_W - 1)))
				>> dam_pkg::FRAC_W;
			acc += (s.tone_sample < 0) ? -scaled : scaled;
		end
		r.clipped = 1'b1;
		if (acc > 32767) begin
			r.mixed_sample = 16'h7FFF;
		end else if (acc < -32768) begin
			r.mixed_sample = 16'h8000;
		end else begin
			r.mixed_sample = acc[15:0];
			r.clipped = 1'b0;
		end
		return r;
	endfunction

	task automatic flag_mismatch(input string what);
		if (mismatches < PRINT_CAP) $display("MISMATCH @%0t: %s", $time, what);
		mismatches++;
	endtask

	function automatic logic [15:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic queue_sample(input logic [15:0] rx, input logic rcv, input logic lnk_on,
			input logic [15:0] lnk, input logic tv, input logic [15:0] tone);
		mix_in_t s;
		s.rx_sample   = rx;
		s.receiving   = rcv;
		s.link_busy   = lnk_on;
		s.link_sample = lnk;
		s.tone_valid  = tv;
		s.tone_sample = tone;
		sample_q.push_back(s);
	endtask

	// carrier and link held for runs, with the odd flag glitch mixed in
	task automatic queue_random_phase(input int count);
		int run;
		logic rcv;
		logic lnk_on;
		run = 0;
		rcv = 1'b0;
		lnk_on = 1'b0;
		for (int k = 0; k < count; k++) begin
			if (run == 0) begin
				run = $urandom_range(1, 40);
				rcv = ($urandom_range(0, 2) == 0);
				lnk_on = ($urandom_range(0, 2) == 0);
			end
			run--;
			queue_sample(rand_sample(), ($urandom_range(0, 15) == 0) ? !rcv : rcv,
				($urandom_range(0, 15) == 0) ? !lnk_on : lnk_on, rand_sample(),
				($urandom_range(0, 3) != 0), rand_sample());
		end
	endtask

	task automatic wait_idle();
		do @(negedge clk); while (sample_q.size() != 0 || s_tvalid || mix_due.size() != 0);
		repeat (5) @(negedge clk);
	endtask

	task automatic write_reg(input dam_pkg::reg_index_t idx, input logic [24:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			dam_pkg::REG_DUCK_GAIN:    cfg_duck    = val;
			dam_pkg::REG_ATTACK_STEP:  cfg_attack  = val;
			dam_pkg::REG_RELEASE_STEP: cfg_release = val;
			dam_pkg::REG_FULL_DUPLEX:  cfg_duplex  = val[0];
			default: ;
		endcase
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
			tx_gap = 0;
		end else begin
			if (s_tvalid && s_tready) mix_due.push_back(mix_predict(tx_beat));
			if (!s_tvalid || s_tready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					s_tvalid <= 1'b0;
				end else if (sample_q.size() > 0) begin
					tx_beat = sample_q.pop_front();
					s_tdata  <= {tx_beat.tone_sample, tx_beat.link_sample, tx_beat.rx_sample};
					s_tuser  <= {tx_beat.tone_valid, tx_beat.link_busy, tx_beat.receiving};
					s_tvalid <= 1'b1;
					if (tx_calm > 0) begin
						tx_calm--;
					end else if (!no_idle) begin
						case ($urandom_range(0, 19))
							0, 1, 2, 3: tx_gap = $urandom_range(1, 6);
							4: tx_calm = $urandom_range(20, 60);
							default: ;
						endcase
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		mix_out_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_stall = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (mix_due.size() == 0) begin
					flag_mismatch($sformatf("unexpected beat %h", m_tdata));
				end else begin
					want = mix_due.pop_front();
					if (m_tdata !== want.mixed_sample)
						flag_mismatch($sformatf("mixed_sample %h, want %h",
							m_tdata, want.mixed_sample));
					if (m_tuser[0] !== want.clipped)
						flag_mismatch($sformatf("clipped %b, want %b", m_tuser[0], want.clipped));
				end
			end
			if (rx_stall > 0) begin
				rx_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (!no_idle && $urandom_range(0, 5) == 0) rx_stall = $urandom_range(1, 6);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, half duplex
		queue_sample(16'h0000, 1'b0, 1'b0, 16'h0000, 1'b1, 16'h7FFF);
		queue_sample(16'h0000, 1'b0, 1'b0, 16'h0000, 1'b1, 16'h8000);
		queue_sample(16'h7FFF, 1'b1, 1'b1, 16'h7FFF, 1'b0, 16'h7FFF);
		queue_sample(16'h0000, 1'b0, 1'b1, 16'h7FFF, 1'b1, 16'h7FFF);
		queue_sample(16'h0000, 1'b0, 1'b1, 16'h8000, 1'b1, 16'h8000);
		queue_sample(16'h0000, 1'b0, 1'b1, 16'h0000, 1'b0, 16'h7FFF);
		queue_sample(16'h8000, 1'b1, 1'b0, 16'h0000, 1'b0, 16'h0000);
		queue_sample(16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 16'h0000);
		queue_sample(16'h0000, 1'b0, 1'b0, 16'h0000, 1'b1, 16'hFFFF);
		queue_sample(16'h0000, 1'b0, 1'b0, 16'h0000, 1'b1, 16'h0001);
		wait_idle();

		// full duplex, gain jumps straight between mute and unity
		write_reg(dam_pkg::REG_FULL_DUPLEX, 25'd1);
		write_reg(dam_pkg::REG_DUCK_GAIN, 25'd0);
		write_reg(dam_pkg::REG_ATTACK_STEP, dam_pkg::GAIN_ONE);
		write_reg(dam_pkg::REG_RELEASE_STEP, dam_pkg::GAIN_ONE);
		queue_sample(16'h7FFF, 1'b1, 1'b1, 16'h7FFF, 1'b1, 16'h7FFF);
		queue_sample(16'h8000, 1'b1, 1'b1, 16'h8000, 1'b0, 16'h0000);
		queue_sample(16'h7FFF, 1'b1, 1'b1, 16'h0001, 1'b0, 16'h0000);
		queue_sample(16'h7FFF, 1'b1, 1'b0, 16'h7FFF, 1'b1, 16'h7FFF);
		queue_sample(16'h0000, 1'b0, 1'b0, 16'h0000, 1'b1, 16'h7FFF);
		queue_sample(16'h0000, 1'b0, 1'b1, 16'hFFFF, 1'b1, 16'h8000);
		wait_idle();

		// half gain: rounding of exact halves
		write_reg(dam_pkg::REG_DUCK_GAIN, 25'd8388608);
		queue_sample(16'h0000, 1'b1, 1'b0, 16'h0000, 1'b1, 16'h0001);
		queue_sample(16'h0000, 1'b1, 1'b0, 16'h0000, 1'b1, 16'hFFFF);
		queue_sample(16'h0000, 1'b1, 1'b0, 16'h0000, 1'b1, 16'h0003);
		queue_sample(16'h0000, 1'b1, 1'b0, 16'h0000, 1'b1, 16'hFFFD);
		queue_sample(16'h8000, 1'b1, 1'b0, 16'h0000, 1'b1, 16'h8000);
		queue_sample(16'h7FFF, 1'b1, 1'b0, 16'h0000, 1'b1, 16'h0002);
		wait_idle();

		write_reg(dam_pkg::REG_FULL_DUPLEX, 25'd0);
		write_reg(dam_pkg::REG_DUCK_GAIN, dam_pkg::DUCK_GAIN_RST);
		write_reg(dam_pkg::REG_ATTACK_STEP, dam_pkg::ATTACK_STEP_RST);
		write_reg(dam_pkg::REG_RELEASE_STEP, dam_pkg::RELEASE_STEP_RST);
		queue_random_phase(220);
		wait_idle();

		// slowest ramp toward full mute
		write_reg(dam_pkg::REG_FULL_DUPLEX, 25'd1);
		write_reg(dam_pkg::REG_DUCK_GAIN, 25'd0);
		write_reg(dam_pkg::REG_ATTACK_STEP, 25'd1);
		write_reg(dam_pkg::REG_RELEASE_STEP, 25'd1);
		queue_random_phase(200);
		wait_idle();

		// no ducking at all
		write_reg(dam_pkg::REG_FULL_DUPLEX, 25'd0);
		write_reg(dam_pkg::REG_DUCK_GAIN, dam_pkg::GAIN_ONE);
		write_reg(dam_pkg::REG_ATTACK_STEP, dam_pkg::GAIN_ONE);
		write_reg(dam_pkg::REG_RELEASE_STEP, dam_pkg::GAIN_ONE);
		queue_random_phase(200);
		wait_idle();

		for (int p = 0; p < 5; p++) begin
			write_reg(dam_pkg::REG_FULL_DUPLEX, 25'($urandom_range(0, 1)));
			write_reg(dam_pkg::REG_DUCK_GAIN, 25'($urandom_range(0, dam_pkg::GAIN_ONE)));
			write_reg(dam_pkg::REG_ATTACK_STEP,
				25'($urandom_range(1, 1 << $urandom_range(0, 24))));
			write_reg(dam_pkg::REG_RELEASE_STEP,
				25'($urandom_range(1, 1 << $urandom_range(0, 24))));
			if (p == 4) no_idle = 1'b1;
			queue_random_phase((p == 4) ? 230 : 200);
			wait_idle();
		end

		repeat (10) @(negedge clk);
		if (mix_due.size() != 0) flag_mismatch($sformatf("%0d results missing", mix_due.size()));
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
